// ===== hdl/hashed_name_table_macros.svh =====
// Assertion helpers shared by the blocks that check themselves.
`ifndef HASHED_NAME_TABLE_MACROS_SVH
`define HASHED_NAME_TABLE_MACROS_SVH

// Property that must hold at every clock edge out of reset.
`define HNT_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// Condition that must be followed by a consequence in the next cycle.
`define HNT_ASSERT_NEXT(lbl, pre, post, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (pre) |=> (post)) else $error(msg);

`endif

// ===== hdl/hnt_pkg.sv =====
package hnt_pkg;

  // Store geometry.
  localparam int unsigned DEPTH       = 1024;
  localparam int unsigned VALUE_WIDTH = 64;
  localparam int unsigned ADDR_W      = $clog2(DEPTH);

  // Fixed field widths.
  localparam int unsigned CNT_W   = 11;  // table_size register
  localparam int unsigned HASH_W  = 64;
  localparam int unsigned DATA_W  = 64;
  localparam int unsigned SLOT_W  = 10;
  localparam int unsigned BITC_W  = $clog2(HASH_W);
  localparam int unsigned CMP_W   = (ADDR_W > CNT_W) ? ADDR_W : CNT_W;
  localparam int unsigned CFG_IDX_W = 2;

  // Operation codes.
  localparam logic [1:0] KIND_SET  = 2'd0;
  localparam logic [1:0] KIND_GET  = 2'd1;
  localparam logic [1:0] KIND_FILL = 2'd2;

  // Result status codes.
  localparam logic [1:0] STATUS_OK           = 2'd0;
  localparam logic [1:0] STATUS_FILL_REFUSED = 2'd1;
  localparam logic [1:0] STATUS_NOT_FOUND    = 2'd2;

  // Register indexes.
  localparam logic [CFG_IDX_W-1:0] CFG_TABLE_SIZE   = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_POINTER_MODE = 2'd1;

  localparam logic [CNT_W-1:0] TABLE_SIZE_RST = 11'd1024;

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_DIV,
    ST_EXEC,
    ST_READ,
    ST_FILL,
    ST_RESP
  } state_e;

  typedef struct packed {
    logic accept;       // input transaction taken this cycle
    logic div_step;     // one restoring-division step
    logic sweep_clr;    // rewind the sweep address
    logic clr_wr;       // write zero at the sweep address
    logic fill_wr;      // write the fill value at the sweep address
    logic set_wr;       // write the set value at the hashed slot
    logic get_rd;       // read the hashed slot
    logic load_result;  // capture the result into the output register
  } hnt_cmd_t;

  typedef struct packed {
    logic       div_last;
    logic       sweep_end_depth;
    logic       sweep_end_count;
    logic       pointer_mode;
    logic [1:0] kind;
    logic       out_busy;
  } hnt_sts_t;

endpackage

// ===== hdl/hnt_ram.sv =====
module hnt_ram #(
  parameter int unsigned Width = 64,
  parameter int unsigned Depth = 1024
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic                     re_i,
  input  logic [$clog2(Depth)-1:0] addr_i,
  input  logic [Width-1:0]         wdata_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[addr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[addr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ===== hdl/hnt_ctrl.sv =====
module hnt_ctrl import hnt_pkg::*; (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     in_valid_i,
  input  logic     last_i,
  output logic     in_stall_o,
  input  hnt_sts_t sts_i,
  output hnt_cmd_t cmd_o
);

  state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_CLEAR;
    end else begin
      state_q <= state_d;
    end
  end

  // Next state.
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_CLEAR: begin
        if (sts_i.sweep_end_depth) state_d = ST_IDLE;
      end
      ST_IDLE: begin
        if (in_valid_i && last_i) state_d = ST_DIV;
      end
      ST_DIV: begin
        if (sts_i.div_last) state_d = ST_EXEC;
      end
      ST_EXEC: begin
        unique case (sts_i.kind)
          KIND_GET:  state_d = ST_READ;
          KIND_FILL: state_d = sts_i.pointer_mode ? ST_RESP : ST_FILL;
          default:   state_d = ST_RESP;
        endcase
      end
      ST_READ: begin
        state_d = ST_RESP;
      end
      ST_FILL: begin
        if (sts_i.sweep_end_count) state_d = ST_RESP;
      end
      ST_RESP: begin
        if (!sts_i.out_busy) state_d = ST_IDLE;
      end
    endcase
  end

  // Commands.
  always_comb begin
    cmd_o = '0;
    unique case (state_q)
      ST_CLEAR: cmd_o.clr_wr = 1'b1;
      ST_IDLE:  cmd_o.accept = in_valid_i;
      ST_DIV:   cmd_o.div_step = 1'b1;
      ST_EXEC: begin
        unique case (sts_i.kind)
          KIND_SET:  cmd_o.set_wr = 1'b1;
          KIND_GET:  cmd_o.get_rd = 1'b1;
          KIND_FILL: cmd_o.sweep_clr = !sts_i.pointer_mode;
          default:   cmd_o = '0;
        endcase
      end
      ST_READ:  cmd_o = '0;
      ST_FILL:  cmd_o.fill_wr = 1'b1;
      ST_RESP:  cmd_o.load_result = !sts_i.out_busy;
    endcase
  end

  assign in_stall_o = (state_q != ST_IDLE);

`include "hashed_name_table_macros.svh"

  `HNT_ASSERT_NEXT(a_last_starts_div, in_valid_i && !in_stall_o && last_i, state_q == ST_DIV, "last byte did not start the modulo")
  `HNT_ASSERT(a_one_store_access, !(cmd_o.clr_wr && cmd_o.fill_wr) && !(cmd_o.set_wr && cmd_o.get_rd), "two store accesses in one cycle")

endmodule

// ===== hdl/hnt_dpath.sv =====
module hnt_dpath import hnt_pkg::*; (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  // configuration
  input  logic                   cfg_valid_i,
  output logic                   cfg_ready_o,
  input  logic [CFG_IDX_W-1:0]   cfg_index_i,
  input  logic [CNT_W-1:0]       cfg_data_i,
  // input payload
  input  logic [1:0]             kind_i,
  input  logic [7:0]             name_byte_i,
  input  logic                   last_i,
  input  logic [DATA_W-1:0]      write_value_i,
  // controller
  input  hnt_cmd_t               cmd_i,
  output hnt_sts_t               sts_o,
  // store port
  output logic                   ram_we_o,
  output logic                   ram_re_o,
  output logic [ADDR_W-1:0]      ram_addr_o,
  output logic [VALUE_WIDTH-1:0] ram_wdata_o,
  input  logic [VALUE_WIDTH-1:0] ram_rdata_i,
  // result channel
  output logic                   out_valid_o,
  input  logic                   out_stall_i,
  output logic [1:0]             status_o,
  output logic [DATA_W-1:0]      read_value_o,
  output logic [SLOT_W-1:0]      slot_index_o
);

  logic [CNT_W-1:0]       table_size_q;
  logic                   pointer_mode_q;
  logic [HASH_W-1:0]      hash_q, hash_upd;
  logic [HASH_W-1:0]      dividend_q;
  logic [CNT_W-1:0]       rem_q;
  logic [CNT_W:0]         rem_shift;
  logic [BITC_W-1:0]      bit_cnt_q;
  logic [1:0]             kind_q;
  logic [VALUE_WIDTH-1:0] wval_q;
  logic [ADDR_W-1:0]      sweep_q;
  logic [CNT_W-1:0]       count;
  logic [CNT_W+ADDR_W-1:0] slot_wide;
  logic [ADDR_W-1:0]      slot;
  logic                   out_valid_q;
  logic [1:0]             status_q, status_d;
  logic [DATA_W-1:0]      rval_q, rval_d;
  logic [SLOT_W-1:0]      slot_idx_q;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      table_size_q   <= TABLE_SIZE_RST;
      pointer_mode_q <= 1'b0;
    end else if (cfg_valid_i) begin
      unique case (cfg_index_i)
        CFG_TABLE_SIZE:   table_size_q   <= cfg_data_i;
        CFG_POINTER_MODE: pointer_mode_q <= cfg_data_i[0];
        default:          ;
      endcase
    end
  end

  // Slots in use: zero acts as one, anything past the store acts as the store size.
  always_comb begin
    if (table_size_q == '0) begin
      count = CNT_W'(1);
    end else if (32'(table_size_q) > DEPTH) begin
      count = CNT_W'(DEPTH);
    end else begin
      count = table_size_q;
    end
  end

  // hash * 97 + byte, as shifts and adds; a zero byte leaves the hash as it is.
  assign hash_upd = (name_byte_i == 8'd0) ? hash_q :
                    {hash_q[HASH_W-7:0], 6'b0} + {hash_q[HASH_W-6:0], 5'b0} +
                    hash_q + HASH_W'(name_byte_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      hash_q <= '0;
    end else if (cmd_i.accept) begin
      hash_q <= last_i ? '0 : hash_upd;
    end
  end

  // Restoring division, one quotient bit a cycle; only the remainder is kept.
  assign rem_shift = {rem_q, dividend_q[HASH_W-1]};

  always_ff @(posedge clk_i) begin
    if (cmd_i.accept && last_i) begin
      dividend_q <= hash_upd;
      rem_q      <= '0;
      bit_cnt_q  <= BITC_W'(HASH_W - 1);
      kind_q     <= kind_i;
      wval_q     <= write_value_i[VALUE_WIDTH-1:0];
    end else if (cmd_i.div_step) begin
      dividend_q <= {dividend_q[HASH_W-2:0], 1'b0};
      bit_cnt_q  <= bit_cnt_q - BITC_W'(1);
      if (rem_shift >= {1'b0, count}) begin
        rem_q <= CNT_W'(rem_shift - {1'b0, count});
      end else begin
        rem_q <= rem_shift[CNT_W-1:0];
      end
    end
  end

  assign slot_wide = {{ADDR_W{1'b0}}, rem_q};
  assign slot      = slot_wide[ADDR_W-1:0];

  // Sweep address for the clearing pass and for fill.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sweep_q <= '0;
    end else if (cmd_i.sweep_clr) begin
      sweep_q <= '0;
    end else if (cmd_i.clr_wr || cmd_i.fill_wr) begin
      sweep_q <= sweep_q + ADDR_W'(1);
    end
  end

  assign ram_we_o    = cmd_i.clr_wr || cmd_i.fill_wr || cmd_i.set_wr;
  assign ram_re_o    = cmd_i.get_rd;
  assign ram_addr_o  = (cmd_i.clr_wr || cmd_i.fill_wr) ? sweep_q : slot;
  assign ram_wdata_o = cmd_i.clr_wr ? '0 : wval_q;

  // Result assembly.
  always_comb begin
    status_d = STATUS_OK;
    rval_d   = '0;
    unique case (kind_q)
      KIND_GET: begin
        rval_d = DATA_W'(ram_rdata_i);
        if (pointer_mode_q && (ram_rdata_i == '0)) status_d = STATUS_NOT_FOUND;
      end
      KIND_FILL: begin
        if (pointer_mode_q) status_d = STATUS_FILL_REFUSED;
      end
      default: status_d = STATUS_OK;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.load_result) begin
      out_valid_q <= 1'b1;
    end else if (out_valid_q && !out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load_result) begin
      status_q   <= status_d;
      rval_q     <= rval_d;
      slot_idx_q <= (kind_q == KIND_FILL) ? '0 : rem_q[SLOT_W-1:0];
    end
  end

  assign out_valid_o  = out_valid_q;
  assign status_o     = status_q;
  assign read_value_o = rval_q;
  assign slot_index_o = slot_idx_q;

  assign sts_o.div_last        = (bit_cnt_q == '0);
  assign sts_o.sweep_end_depth = (sweep_q == ADDR_W'(DEPTH - 1));
  assign sts_o.sweep_end_count = (CMP_W'(sweep_q) == CMP_W'(count - CNT_W'(1)));
  assign sts_o.pointer_mode    = pointer_mode_q;
  assign sts_o.kind            = kind_q;
  assign sts_o.out_busy        = out_valid_q && out_stall_i;

`include "hashed_name_table_macros.svh"

  `HNT_ASSERT(a_rem_below_count, cmd_i.div_step |-> (rem_q < count), "remainder reached the divisor")
  `HNT_ASSERT(a_fill_in_range, cmd_i.fill_wr |-> (CMP_W'(sweep_q) < CMP_W'(count)), "fill wrote past the slots in use")
  `HNT_ASSERT_NEXT(a_result_shown, cmd_i.load_result, out_valid_q, "loaded result not presented")

endmodule

// ===== hdl/hashed_name_table.sv =====
// Direct-mapped table of DEPTH entries addressed by a polynomial hash of a
// byte-string name (hash = hash*97 + byte, zero bytes skipped). Stream the
// name one byte per transaction; non-final bytes are taken one per cycle.
// The transaction with last set launches the operation: a bit-serial
// modulo of the hash by the slot count, then an execute state (set writes
// the slot, get reads it and waits in a read state, fill rewinds the sweep
// and then writes every slot in use; refused fill and unused kind do
// nothing) and a result state that loads the result register; the input
// is stalled until the block is back in idle. The store has a single
// port; the result register lets one more name stream in while a result
// waits, and that name's operation runs, but its result and the input hold
// until the waiting result is taken. After reset the store is zeroed by a
// clearing pass over all DEPTH (1024) entries during which no input
// transaction is taken; configuration writes are taken at any time but
// must be issued only while the table is idle.
module hashed_name_table import hnt_pkg::*; (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  // configuration write channel
  input  logic                 cfg_valid_i,
  output logic                 cfg_ready_o,
  input  logic [CFG_IDX_W-1:0] cfg_index_i,
  input  logic [CNT_W-1:0]     cfg_data_i,
  // input channel
  input  logic                 in_valid_i,
  output logic                 in_stall_o,
  input  logic [1:0]           kind_i,
  input  logic [7:0]           name_byte_i,
  input  logic                 last_i,
  input  logic [DATA_W-1:0]    write_value_i,
  // result channel
  output logic                 out_valid_o,
  input  logic                 out_stall_i,
  output logic [1:0]           status_o,
  output logic [DATA_W-1:0]    read_value_o,
  output logic [SLOT_W-1:0]    slot_index_o
);

  hnt_cmd_t               cmd;
  hnt_sts_t               sts;
  logic                   ram_we;
  logic                   ram_re;
  logic [ADDR_W-1:0]      ram_addr;
  logic [VALUE_WIDTH-1:0] ram_wdata;
  logic [VALUE_WIDTH-1:0] ram_rdata;

  // Sequencer: clearing pass, byte intake, modulo, store access, result.
  hnt_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .last_i     (last_i),
    .in_stall_o (in_stall_o),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  // Hash accumulator, divider, registers, sweep address and result register.
  hnt_dpath u_dpath (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_valid_i   (cfg_valid_i),
    .cfg_ready_o   (cfg_ready_o),
    .cfg_index_i   (cfg_index_i),
    .cfg_data_i    (cfg_data_i),
    .kind_i        (kind_i),
    .name_byte_i   (name_byte_i),
    .last_i        (last_i),
    .write_value_i (write_value_i),
    .cmd_i         (cmd),
    .sts_o         (sts),
    .ram_we_o      (ram_we),
    .ram_re_o      (ram_re),
    .ram_addr_o    (ram_addr),
    .ram_wdata_o   (ram_wdata),
    .ram_rdata_i   (ram_rdata),
    .out_valid_o   (out_valid_o),
    .out_stall_i   (out_stall_i),
    .status_o      (status_o),
    .read_value_o  (read_value_o),
    .slot_index_o  (slot_index_o)
  );

  // Slot store: one port, registered read that holds until the next read.
  hnt_ram #(
    .Width (VALUE_WIDTH),
    .Depth (DEPTH)
  ) u_store (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .re_i    (ram_re),
    .addr_i  (ram_addr),
    .wdata_i (ram_wdata),
    .rdata_o (ram_rdata)
  );

endmodule

// ===== sim/hashed_name_table_test.sv =====
module hashed_name_table_test;
  import hnt_pkg::*;

  // Clock, run length and the handshake pressure figures.
  localparam int unsigned CLK_HALF      = 6;
  localparam int unsigned CYCLE_LIMIT   = 1_000_000;
  localparam int unsigned SETTLE_CYCLES = 100;   // settle margin after the last result is back
  localparam int unsigned BACKLOG_HOLD  = 500;   // long receiver hold-off
  localparam int unsigned MAX_NAME      = 16;    // bytes in the longest name
  localparam int unsigned POOL_N        = 8;     // reusable names per phase

  // Unused operation code and unused register index.
  localparam logic [1:0]           KIND_NOP      = 2'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_SPARE_IDX = 2'd2;

  localparam logic [HASH_W-1:0] HASH_MULT  = 64'd97;
  localparam logic [DATA_W-1:0] VALUE_MASK = {DATA_W{1'b1}} >> (DATA_W - VALUE_WIDTH);

  typedef struct packed {
    logic [1:0]        status;
    logic [DATA_W-1:0] read_value;
    logic [SLOT_W-1:0] slot_index;
  } table_result_t;

  logic                 clk_i = 1'b0;
  logic                 rst_ni;
  logic                 cfg_valid_i;
  logic                 cfg_ready_o;
  logic [CFG_IDX_W-1:0] cfg_index_i;
  logic [CNT_W-1:0]     cfg_data_i;
  logic                 in_valid_i;
  logic                 in_stall_o;
  logic [1:0]           kind_i;
  logic [7:0]           name_byte_i;
  logic                 last_i;
  logic [DATA_W-1:0]    write_value_i;
  logic                 out_valid_o;
  logic                 out_stall_i;
  logic [1:0]           status_o;
  logic [DATA_W-1:0]    read_value_o;
  logic [SLOT_W-1:0]    slot_index_o;

  // Mirror of the table: running hash, slot contents and both registers.
  logic [HASH_W-1:0] name_hash;
  logic [DATA_W-1:0] slot_mirror [DEPTH];
  logic [CNT_W-1:0]  size_mirror;
  logic              pointer_mirror;

  table_result_t expected_q [$];
  int unsigned   error_count;
  int unsigned   cycle_count;
  bit            idling_on;
  bit            backlog_req;

  hashed_name_table i_dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_valid_i   (cfg_valid_i),
    .cfg_ready_o   (cfg_ready_o),
    .cfg_index_i   (cfg_index_i),
    .cfg_data_i    (cfg_data_i),
    .in_valid_i    (in_valid_i),
    .in_stall_o    (in_stall_o),
    .kind_i        (kind_i),
    .name_byte_i   (name_byte_i),
    .last_i        (last_i),
    .write_value_i (write_value_i),
    .out_valid_o   (out_valid_o),
    .out_stall_i   (out_stall_i),
    .status_o      (status_o),
    .read_value_o  (read_value_o),
    .slot_index_o  (slot_index_o)
  );

  always #CLK_HALF clk_i = ~clk_i;

  // Bound the run; a hang anywhere ends here.
  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("status: fail");
      $finish;
    end
  end

  // Slot count actually used: zero acts as one, anything above DEPTH as DEPTH.
  function automatic int unsigned slots_in_use(input logic [CNT_W-1:0] size);
    if (size == '0) return 1;
    if (size > DEPTH) return DEPTH;
    return size;
  endfunction

  // Advance the table mirror by one name byte; return 1 when the byte
  // closes a name and so produces a result.
  function automatic bit predict_table_op(input logic [1:0] kind, input logic [7:0] b,
                                          input logic is_last,
                                          input logic [DATA_W-1:0] value,
                                          output table_result_t res);
    int unsigned       count;
    int unsigned       i;
    logic [HASH_W-1:0] slot;
    res = '0;
    res.status = STATUS_OK;
    // Zero bytes leave the hash alone.
    if (b != 8'd0) name_hash = name_hash * HASH_MULT + HASH_W'(b);
    if (!is_last) return 1'b0;
    count = slots_in_use(size_mirror);
    slot = name_hash % HASH_W'(count);
    name_hash = '0;
    res.slot_index = slot[SLOT_W-1:0];
    case (kind)
      KIND_SET: slot_mirror[slot[ADDR_W-1:0]] = value & VALUE_MASK;
      KIND_GET: begin
        res.read_value = slot_mirror[slot[ADDR_W-1:0]];
        if (pointer_mirror && res.read_value == '0) res.status = STATUS_NOT_FOUND;
      end
      KIND_FILL: begin
        res.slot_index = '0;
        if (pointer_mirror) begin
          res.status = STATUS_FILL_REFUSED;
        end else begin
          for (i = 0; i < count; i++) slot_mirror[i] = value & VALUE_MASK;
        end
      end
      default: ;  // unused kind: slot reported, nothing touched
    endcase
    return 1'b1;
  endfunction

  // Compare every accepted result with the oldest prediction.
  always @(posedge clk_i) begin : result_check
    table_result_t want;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (expected_q.size() == 0) begin
        $error("result with nothing expected: status %0d read_value %h slot_index %0d",
               status_o, read_value_o, slot_index_o);
        error_count++;
      end else begin
        want = expected_q.pop_front();
        if (status_o !== want.status) begin
          $error("status: expected %0d, actual %0d", want.status, status_o);
          error_count++;
        end
        if (read_value_o !== want.read_value) begin
          $error("read_value: expected %h, actual %h", want.read_value, read_value_o);
          error_count++;
        end
        if (slot_index_o !== want.slot_index) begin
          $error("slot_index: expected %0d, actual %0d", want.slot_index, slot_index_o);
          error_count++;
        end
      end
    end
  end

  // Result-side stall: a requested long hold-off, else random bursts while idling is on.
  always begin
    @(posedge clk_i);
    if (backlog_req) begin
      backlog_req = 1'b0;
      out_stall_i <= 1'b1;
      repeat (BACKLOG_HOLD) @(posedge clk_i);
      out_stall_i <= 1'b0;
    end else if (idling_on && $urandom_range(0, 9) == 0) begin
      out_stall_i <= 1'b1;
      repeat ($urandom_range(1, 19)) @(posedge clk_i);
      out_stall_i <= 1'b0;
    end
  end

  function automatic logic [DATA_W-1:0] random_value();
    case ($urandom_range(0, 9))
      0:       return '0;
      1:       return '1;
      default: return {$urandom, $urandom};
    endcase
  endfunction

  function automatic logic [8*MAX_NAME-1:0] random_name_bits();
    logic [8*MAX_NAME-1:0] bits;
    int unsigned           i;
    for (i = 0; i < MAX_NAME; i++)
      bits[8*i +: 8] = ($urandom_range(0, 4) == 0) ? 8'd0 : 8'($urandom_range(1, 255));
    return bits;
  endfunction

  function automatic int unsigned random_name_len();
    if ($urandom_range(0, 9) == 0) return $urandom_range(7, MAX_NAME);
    return $urandom_range(1, 6);
  endfunction

  // Write one register and update the mirror once the transaction is taken.
  task automatic write_register(input logic [CFG_IDX_W-1:0] idx,
                                input logic [CNT_W-1:0] data);
    @(posedge clk_i);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= data;
    do @(posedge clk_i); while (!cfg_ready_o);
    cfg_valid_i <= 1'b0;
    if (idx == CFG_TABLE_SIZE) size_mirror = data;
    else if (idx == CFG_POINTER_MODE) pointer_mirror = data[0];
  endtask

  // Offer one name byte. Valid stays high on return so that the next byte
  // can follow back to back; anything that lets time pass drops it first.
  task automatic send_byte(input logic [1:0] kind, input logic [7:0] b, input logic is_last,
                           input logic [DATA_W-1:0] value);
    table_result_t res;
    if (idling_on && $urandom_range(0, 11) == 0) begin
      in_valid_i <= 1'b0;
      repeat ($urandom_range(1, 19)) @(posedge clk_i);
    end
    in_valid_i    <= 1'b1;
    kind_i        <= kind;
    name_byte_i   <= b;
    last_i        <= is_last;
    write_value_i <= value;
    do @(posedge clk_i); while (in_stall_o);
    if (predict_table_op(kind, b, is_last, value, res)) expected_q.push_back(res);
  endtask

  // Stream a whole name; kind and value on the leading bytes are noise.
  task automatic send_name(input logic [1:0] kind, input logic [8*MAX_NAME-1:0] bits,
                           input int unsigned len, input logic [DATA_W-1:0] value);
    int unsigned i;
    for (i = 0; i + 1 < len; i++)
      send_byte(2'($urandom_range(0, 3)), bits[8*i +: 8], 1'b0, random_value());
    send_byte(kind, bits[8*(len-1) +: 8], 1'b1, value);
  endtask

  // Drop valid and hold until every predicted result is back and the
  // block has had time to settle.
  task automatic wait_for_results();
    in_valid_i <= 1'b0;
    while (expected_q.size() != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  // Every operation at reset settings, on the freshly cleared store.
  task automatic test_basic_ops();
    send_name(KIND_GET, 128'h41, 1, '0);
    send_name(KIND_SET, 128'hFF, 1, '1);
    send_name(KIND_GET, 128'hFF, 1, '0);
    // all-zero names hash to slot zero whatever their length
    send_name(KIND_SET, 128'h00, 1, 64'h0123_4567_89AB_CDEF);
    send_name(KIND_GET, 128'h0000, 2, '0);
    send_name(KIND_NOP, 128'h7F, 1, '1);
    // longest name of 0xFF bytes wraps the hash
    send_name(KIND_SET, {MAX_NAME{8'hFF}}, MAX_NAME, 64'h8000_0000_0000_0001);
    send_name(KIND_GET, {MAX_NAME{8'hFF}}, MAX_NAME, '0);
    send_name(KIND_FILL, 128'h42, 1, 64'h5555_5555_5555_5555);
    send_name(KIND_GET, 128'h41, 1, '0);
    send_name(KIND_SET, 128'hFF, 1, '0);
    send_name(KIND_GET, 128'hFF, 1, '0);
    wait_for_results();
  endtask

  // Out-of-range slot counts clamp to one and to DEPTH.
  task automatic test_size_extremes();
    write_register(CFG_TABLE_SIZE, 11'd0);
    send_name(KIND_SET, 128'h1234, 2, 64'hDEAD_BEEF_0000_0001);
    send_name(KIND_GET, 128'h99, 1, '0);
    send_name(KIND_FILL, 128'h01, 1, 64'hA5A5_A5A5_A5A5_A5A5);
    wait_for_results();
    write_register(CFG_TABLE_SIZE, 11'd2047);
    send_name(KIND_GET, 128'hFFFE_FDFC, 4, '0);
    send_name(KIND_SET, 128'h0102_0304_0506_0708, 8, 64'hFEDC_BA98_7654_3210);
    send_name(KIND_GET, 128'h0102_0304_0506_0708, 8, '0);
    wait_for_results();
  endtask

  // Not-found on zero entries, refused fill; also an unused register index.
  task automatic test_pointer_mode();
    write_register(CFG_TABLE_SIZE, 11'd13);
    write_register(CFG_POINTER_MODE, 11'h7FF);
    write_register(CFG_SPARE_IDX, CNT_W'($urandom));
    send_name(KIND_SET, 128'h55, 1, '0);
    send_name(KIND_GET, 128'h55, 1, '0);
    send_name(KIND_FILL, 128'h66, 1, '1);
    send_name(KIND_GET, 128'h77, 1, '0);
    wait_for_results();
    write_register(CFG_POINTER_MODE, 11'h7FE);
    wait_for_results();
  endtask

  // Hold the result side off long enough that the block backs up and
  // stalls its input while names keep coming.
  task automatic test_result_backlog();
    int unsigned n;
    idling_on = 1'b0;
    wait_for_results();
    backlog_req = 1'b1;
    for (n = 0; n < 8; n++)
      send_name((n % 2 == 0) ? KIND_SET : KIND_GET, random_name_bits(), 2, random_value());
    wait_for_results();
  endtask

  // One phase of random traffic at a given setting. Names come mostly
  // from a small pool so that gets land on slots that were set.
  task automatic test_random_traffic(input logic [CNT_W-1:0] size, input logic ptr,
                                     input bit idle, input int unsigned n_items);
    logic [8*MAX_NAME-1:0] pool_bits [POOL_N];
    int unsigned           pool_len [POOL_N];
    logic [8*MAX_NAME-1:0] bits;
    int unsigned           len;
    int unsigned           sent;
    int unsigned           fill_pct;
    int unsigned           r;
    int unsigned           p;
    logic [1:0]            kind;
    wait_for_results();
    write_register(CFG_TABLE_SIZE, size);
    write_register(CFG_POINTER_MODE, CNT_W'({10'($urandom), ptr}));
    idling_on = idle;
    for (p = 0; p < POOL_N; p++) begin
      pool_bits[p] = random_name_bits();
      pool_len[p]  = random_name_len();
    end
    // keep long fill walks rare on big tables
    fill_pct = (slots_in_use(size) <= 64) ? 8 : 1;
    sent = 0;
    while (sent < n_items) begin
      if ($urandom_range(0, 9) < 6) begin
        p    = $urandom_range(0, POOL_N - 1);
        bits = pool_bits[p];
        len  = pool_len[p];
      end else begin
        bits = random_name_bits();
        len  = random_name_len();
      end
      r = $urandom_range(0, 99);
      if (r < fill_pct) kind = KIND_FILL;
      else if (r < fill_pct + 5) kind = KIND_NOP;
      else if (r < 50) kind = KIND_SET;
      else kind = KIND_GET;
      send_name(kind, bits, len, random_value());
      sent += len;
    end
    wait_for_results();
  endtask

  initial begin
    // Drive every input to a known value before the first edge.
    rst_ni        = 1'b0;
    cfg_valid_i   = 1'b0;
    cfg_index_i   = '0;
    cfg_data_i    = '0;
    in_valid_i    = 1'b0;
    kind_i        = KIND_SET;
    name_byte_i   = '0;
    last_i        = 1'b0;
    write_value_i = '0;
    out_stall_i   = 1'b0;
    error_count   = 0;
    cycle_count   = 0;
    idling_on     = 1'b1;
    backlog_req   = 1'b0;
    name_hash      = '0;
    size_mirror    = TABLE_SIZE_RST;
    pointer_mirror = 1'b0;
    foreach (slot_mirror[i]) slot_mirror[i] = '0;

    // Reset once; the block then clears its store with input stalled.
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;

    test_basic_ops();
    test_size_extremes();
    test_pointer_mode();
    test_result_backlog();

    test_random_traffic(11'd1, 1'b0, 1'b1, 150);
    test_random_traffic(11'd7, 1'b1, 1'b1, 200);
    test_random_traffic(11'd1024, 1'b0, 1'b1, 250);
    test_random_traffic(11'd2047, 1'b1, 1'b0, 150);
    test_random_traffic(CNT_W'($urandom_range(2, 1023)), 1'b0, 1'b1, 250);
    test_random_traffic(11'd0, 1'b0, 1'b1, 100);
    test_random_traffic(11'd64, 1'b1, 1'b1, 250);
    test_random_traffic(CNT_W'($urandom_range(1, 2047)), 1'($urandom), 1'b1, 250);
    // closing stretch runs with no idling on either side
    test_random_traffic(11'd97, 1'b0, 1'b0, 200);

    wait_for_results();
    if (error_count == 0 && expected_q.size() == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule

// ===== filelist.f =====
+incdir+hdl
hdl/hnt_pkg.sv
hdl/hnt_ram.sv
hdl/hnt_ctrl.sv
hdl/hnt_dpath.sv
hdl/hashed_name_table.sv
sim/hashed_name_table_test.sv
